// File: rtl/core/ern_pkg.sv
// ----------------------------------------------------------------------------
// ern_pkg: shared types and constants for the exact rational notional block
// Trade and result words, status codes, register indexes and controller
// states.
// ----------------------------------------------------------------------------
package ern_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 6;
   localparam int CSR_COUNT = 6;

   localparam logic [63:0] UMAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - VALUE_WIDTH);
   localparam logic [63:0] SMAX = UMAX >> 1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_BAD_INC   = 3'd1,
      ST_NEG_PRICE = 3'd2,
      ST_INEXACT   = 3'd3,
      ST_UOVF      = 3'd4,
      ST_SOVF      = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      REG_TICK_NUM = 3'd0,
      REG_TICK_DEN = 3'd1,
      REG_LOT_NUM  = 3'd2,
      REG_LOT_DEN  = 3'd3,
      REG_ATOM_NUM = 3'd4,
      REG_ATOM_DEN = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic        side;
      logic [63:0] price;
      logic [63:0] quantity;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [62:0] notional;
      logic [63:0] cash_effect;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_GCD,        // Euclid: a <= b, b <= a mod b
      S_MOD,        // waiting on divider
      S_DIV_NUM,    // num / g
      S_DIV_DEN,    // den / g
      S_CHECK,
      S_MUL,        // checked multiply step
      S_MUL_WAIT,
      S_MUL_RUN,    // waiting on shift-add multiplier
      S_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load;
      logic       gcd_init;     // a <= nums[i], b <= dens[j]
      logic       div_start;
      logic [1:0] div_sel;      // 0 a mod b, 1 num/g, 2 den/g, 3 umax/mag
      logic       gcd_step;
      logic       num_write;
      logic       den_write;
      logic       mul_init;
      logic       mul_step;     // start mag * nums[i] on the shift-add unit
      logic [2:0] num_idx;
      logic [1:0] den_idx;
   } cmd_type;

   localparam logic [1:0] DSEL_MOD = 2'd0;
   localparam logic [1:0] DSEL_NUM = 2'd1;
   localparam logic [1:0] DSEL_DEN = 2'd2;
   localparam logic [1:0] DSEL_LIM = 2'd3;

   // datapath to controller
   typedef struct packed {
      logic div_done;
      logic mul_done;
      logic b_zero;
      logic g_zero;
      logic bad_inc;
      logic neg_price;
      logic dens_one;
      logic mag_zero;
      logic mul_ovf;
   } sts_type;

endpackage

// File: rtl/core/ern_div.sv
// ----------------------------------------------------------------------------
// ern_div: 64-bit restoring divider
// One quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module ern_div
   import ern_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] dividend,
   input  logic [63:0] divisor,
   output logic        done,
   output logic [63:0] quotient,
   output logic [63:0] remainder
);

   logic [63:0] q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [64:0] trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[63]} - {1'b0, d_ff};
      if (start) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = 7'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[64]) begin
            r_in = trial[63:0];
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = {r_ff[62:0], q_ff[63]};
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;

endmodule

// File: rtl/core/ern_datapath.sv
// ----------------------------------------------------------------------------
// ern_datapath: operand registers, gcd registers and shared divider
// Holds the five numerators, three denominators and the running product.
// The product runs on a one-bit-per-cycle shift-add multiplier.
// ----------------------------------------------------------------------------
module ern_datapath
   import ern_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   input  req_type     req,
   input  logic [63:0] tick_num,
   input  logic [63:0] tick_den,
   input  logic [63:0] lot_num,
   input  logic [63:0] lot_den,
   input  logic [63:0] atom_num,
   input  logic [63:0] atom_den,
   output sts_type     sts,
   output logic [63:0] mag
);

   logic [63:0] nums_ff [5];
   logic [63:0] dens_ff [3];
   logic [63:0] a_ff, b_ff, mag_ff;
   logic        bad_ff, neg_ff;
   logic [63:0] dvd, dvs, quo, rem, cur_num;
   logic        div_done;
   logic [63:0] prod_ff, prod_in, mcand_ff, mplr_ff;
   logic [5:0]  mcnt_ff;
   logic        mrun_ff, mdone_ff;

   assign cur_num = nums_ff[cmd.num_idx];

   always_comb begin
      case (cmd.div_sel)
         DSEL_MOD: begin dvd = a_ff;            dvs = b_ff; end
         DSEL_NUM: begin dvd = cur_num;         dvs = a_ff; end
         DSEL_DEN: begin dvd = dens_ff[cmd.den_idx]; dvs = a_ff; end
         default:  begin dvd = UMAX;            dvs = mag_ff; end
      endcase
   end

   ern_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .dividend(dvd), .divisor(dvs),
      .done(div_done), .quotient(quo), .remainder(rem)
   );

   // add the shifted multiplicand for each set multiplier bit
   assign prod_in = mplr_ff[0] ? (prod_ff + mcand_ff) : prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mrun_ff  <= 1'b0;
         mdone_ff <= 1'b0;
         mcnt_ff  <= '0;
      end else begin
         mdone_ff <= mrun_ff && (mcnt_ff == 6'd63);
         if (cmd.mul_step) begin
            mrun_ff <= 1'b1;
            mcnt_ff <= '0;
         end else if (mrun_ff) begin
            mcnt_ff <= mcnt_ff + 6'd1;
            if (mcnt_ff == 6'd63) mrun_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         nums_ff[0] <= req.price;
         nums_ff[1] <= req.quantity;
         nums_ff[2] <= tick_num;
         nums_ff[3] <= lot_num;
         nums_ff[4] <= atom_den;
         dens_ff[0] <= tick_den;
         dens_ff[1] <= lot_den;
         dens_ff[2] <= atom_num;
         bad_ff <= (tick_num == '0) || (tick_den == '0) || (lot_num == '0) ||
                   (lot_den == '0) || (atom_num == '0) || (atom_den == '0);
         neg_ff <= req.price[63];
      end
      if (cmd.gcd_init) begin
         a_ff <= cur_num;
         b_ff <= dens_ff[cmd.den_idx];
      end else if (cmd.gcd_step) begin
         a_ff <= b_ff;
         b_ff <= rem;
      end
      if (cmd.num_write) nums_ff[cmd.num_idx] <= quo;
      if (cmd.den_write) dens_ff[cmd.den_idx] <= quo;
      if (cmd.mul_step) begin
         prod_ff  <= '0;
         mcand_ff <= mag_ff;
         mplr_ff  <= cur_num;
      end else if (mrun_ff) begin
         prod_ff  <= prod_in;
         mcand_ff <= {mcand_ff[62:0], 1'b0};
         mplr_ff  <= {1'b0, mplr_ff[63:1]};
      end
      if (cmd.mul_init) mag_ff <= 64'd1;
      else if (mrun_ff && (mcnt_ff == 6'd63)) mag_ff <= prod_in;
   end

   always_comb begin
      sts.div_done  = div_done;
      sts.mul_done  = mdone_ff;
      sts.b_zero    = (b_ff == '0);
      sts.g_zero    = (a_ff == '0);
      sts.bad_inc   = bad_ff;
      sts.neg_price = neg_ff;
      sts.dens_one  = (dens_ff[0] == 64'd1) && (dens_ff[1] == 64'd1) &&
                      (dens_ff[2] == 64'd1);
      sts.mag_zero  = (mag_ff == '0);
      sts.mul_ovf   = (cur_num > quo);
   end

   assign mag = mag_ff;

endmodule

// File: rtl/core/ern_ctrl.sv
// ----------------------------------------------------------------------------
// ern_ctrl: sequencer for the gcd reductions and checked product
// Walks each denominator across the five numerators, then multiplies if every denominator reduced to one.
// ----------------------------------------------------------------------------
module ern_ctrl
   import ern_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        side,
   input  sts_type     sts,
   input  logic [63:0] mag,
   output cmd_type     cmd,
   output logic        busy,
   output logic        rsp_valid,
   output rsp_type     rsp
);

   state_type   state_ff, state_in;
   logic [2:0]  i_ff, i_in;
   logic [1:0]  j_ff, j_in;
   logic        side_ff, side_in;
   logic        out_ff, out_in;
   status_type  st_ff, st_in;
   logic [62:0] not_ff, not_in;
   logic [63:0] cash_ff, cash_in;

   task automatic finish(input status_type s, input logic [63:0] m, input logic sell);
      begin
         out_in  = 1'b1;
         st_in   = s;
         not_in  = m[62:0];
         cash_in = sell ? m : (64'd0 - m);
         state_in = S_IDLE;
      end
   endtask

   always_comb begin
      state_in = state_ff; i_in = i_ff; j_in = j_ff; side_in = side_ff;
      out_in = 1'b0; st_in = st_ff; not_in = not_ff; cash_in = cash_ff;
      cmd = '0;
      cmd.num_idx = i_ff;
      cmd.den_idx = j_ff;
      unique case (state_ff)
         S_IDLE: if (start) begin
            cmd.load = 1'b1;
            side_in = side;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            i_in = 3'd0; j_in = 2'd0;
            if (sts.bad_inc) finish(ST_BAD_INC, 64'd0, side_ff);
            else if (sts.neg_price) finish(ST_NEG_PRICE, 64'd0, side_ff);
            else begin
               cmd.num_idx = 3'd0; cmd.den_idx = 2'd0;
               cmd.gcd_init = 1'b1;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (sts.b_zero) begin
               if (sts.g_zero) state_in = S_DIV_DEN; // gcd 0: skip, advance
               else begin
                  cmd.div_start = 1'b1; cmd.div_sel = DSEL_NUM;
                  state_in = S_DIV_NUM;
               end
               if (sts.g_zero) state_in = S_CHECK; // reused as advance
               if (sts.g_zero) i_in = i_ff;
            end else begin
               cmd.div_start = 1'b1; cmd.div_sel = DSEL_MOD;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            cmd.div_sel = DSEL_MOD;
            if (sts.div_done) begin
               cmd.gcd_step = 1'b1;
               state_in = S_GCD;
            end
         end
         S_DIV_NUM: begin
            cmd.div_sel = DSEL_NUM;
            if (sts.div_done) begin
               cmd.num_write = 1'b1;
               cmd.div_start = 1'b1; cmd.div_sel = DSEL_DEN;
               state_in = S_DIV_DEN;
            end
         end
         S_DIV_DEN: begin
            cmd.div_sel = DSEL_DEN;
            if (sts.div_done) begin
               cmd.den_write = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            // advance to next (den, num) pair or to the product
            if (i_ff != 3'd4) begin
               i_in = i_ff + 3'd1;
               cmd.num_idx = i_in; cmd.gcd_init = 1'b1;
               state_in = S_GCD;
            end else if (j_ff != 2'd2) begin
               i_in = 3'd0; j_in = j_ff + 2'd1;
               cmd.num_idx = 3'd0; cmd.den_idx = j_in; cmd.gcd_init = 1'b1;
               state_in = S_GCD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!sts.dens_one) finish(ST_INEXACT, 64'd0, side_ff);
            else begin
               cmd.mul_init = 1'b1;
               i_in = 3'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            // a zero product stays zero: skip the limit check and multiply
            if (sts.mag_zero) begin
               if (i_ff == 3'd4) begin
                  state_in = S_LOAD; // result next
                  j_in = 2'd3;
               end else begin
                  i_in = i_ff + 3'd1;
                  state_in = S_MUL;
               end
            end else begin
               cmd.div_start = 1'b1; cmd.div_sel = DSEL_LIM;
               state_in = S_MUL_WAIT;
            end
         end
         S_MUL_WAIT: begin
            cmd.div_sel = DSEL_LIM;
            if (sts.div_done) begin
               if (sts.mul_ovf) finish(ST_UOVF, 64'd0, side_ff);
               else begin
                  cmd.mul_step = 1'b1;
                  state_in = S_MUL_RUN;
               end
            end
         end
         S_MUL_RUN: begin
            if (sts.mul_done) begin
               if (i_ff == 3'd4) begin
                  state_in = S_LOAD; // result next
                  j_in = 2'd3;
               end else begin
                  i_in = i_ff + 3'd1;
                  state_in = S_MUL;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      // after the last product step, reuse S_LOAD with j == 3 as final check
      if (state_ff == S_LOAD && j_ff == 2'd3) begin
         cmd.gcd_init = 1'b0;
         out_in = 1'b0;
         if (mag > SMAX) finish(ST_SOVF, 64'd0, side_ff);
         else finish(ST_OK, mag, side_ff);
         i_in = 3'd0; j_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         out_ff   <= 1'b0;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         out_ff   <= out_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
      side_ff <= side_in;
      st_ff   <= st_in;
      not_ff  <= not_in;
      cash_ff <= cash_in;
   end

   assign busy = (state_ff != S_IDLE) || out_ff;
   assign rsp_valid = out_ff;
   assign rsp = '{status: st_ff, notional: not_ff, cash_effect: cash_ff};

endmodule

// File: rtl/core/exact_rational_notional.sv
// ----------------------------------------------------------------------------
// exact_rational_notional: exact trade notional in quote atoms
// Cancels common factors by gcd, then forms a checked product.
//
//   channel  ports                          handshake
//   trade    req_start/req_busy/req_data    start while not busy
//   result   rsp_valid/rsp_data             one-cycle strobe
//   config   csr_p*                         APB write, pready high
//
// An item ends early when an error is found at entry. Each gcd remainder and
// each division runs on one shared one-bit-per-cycle 64-bit divider, and
// each of the five product steps with a nonzero product takes a limit
// division plus a shift-add multiply. Worst case is fifteen gcds of about
// 93 remainder passes each.
// Reset is synchronous and sets all six registers to 1. The result cannot
// be stalled; busy stays high through the strobe cycle.
// ----------------------------------------------------------------------------
module exact_rational_notional
   import ern_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   output logic                      req_busy,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [63:0]               csr_pwdata,
   output logic [63:0]               csr_prdata,
   output logic                      csr_pready
);

   logic [63:0] regs_ff [CSR_COUNT];
   logic        wr;
   logic [2:0]  idx;
   cmd_type     cmd;
   sts_type     sts;
   logic [63:0] mag;

   assign idx = csr_paddr[5:3];
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CSR_COUNT; k++) regs_ff[k] <= 64'd1;
      end else if (wr && csr_paddr[2:0] == 3'd0 && idx < 3'(CSR_COUNT)) begin
         regs_ff[idx] <= csr_pwdata;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2:0] == 3'd0 && idx < 3'(CSR_COUNT)) csr_prdata = regs_ff[idx];
   end

   ern_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .req(req_data),
      .tick_num(regs_ff[REG_TICK_NUM]), .tick_den(regs_ff[REG_TICK_DEN]),
      .lot_num(regs_ff[REG_LOT_NUM]),   .lot_den(regs_ff[REG_LOT_DEN]),
      .atom_num(regs_ff[REG_ATOM_NUM]), .atom_den(regs_ff[REG_ATOM_DEN]),
      .sts(sts), .mag(mag)
   );

   ern_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .start(req_start && !req_busy), .side(req_data.side),
      .sts(sts), .mag(mag), .cmd(cmd), .busy(req_busy),
      .rsp_valid(rsp_valid), .rsp(rsp_data)
   );

endmodule

// File: bench/ern_notional_checker.sv
// ----------------------------------------------------------------------------
// ern_notional_checker: result checker for the exact rational notional block
// Mirrors the six size registers from observed CSR writes, works out the
// status, notional and cash effect of each accepted trade, and compares
// every result strobe against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module ern_notional_checker
   import ern_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   input  logic                      req_busy,
   input  req_type                   req_data,
   input  logic                      rsp_valid,
   input  rsp_type                   rsp_data,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic                      csr_pready,
   input  logic [CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [63:0]               csr_pwdata,
   output int                        errors,
   output int                        pending
);

   logic [63:0] size_regs [CSR_COUNT];
   rsp_type     notional_queue [$];

   function automatic logic [63:0] euclid(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic rsp_type make_word(status_type st, logic [63:0] mag, logic sell);
      rsp_type w;
      w.status      = st;
      w.notional    = mag[62:0];
      w.cash_effect = sell ? mag : 64'd0 - mag;
      return w;
   endfunction

   function automatic rsp_type trade_notional(req_type t);
      logic [63:0] nums [5];
      logic [63:0] dens [3];
      logic [63:0] g;
      logic [63:0] mag;
      mag = 64'd1;
      foreach (size_regs[k])
         if (size_regs[k] == 0) return make_word(ST_BAD_INC, 0, t.side);
      if (t.price[63]) return make_word(ST_NEG_PRICE, 0, t.side);
      nums[0] = t.price;
      nums[1] = t.quantity;
      nums[2] = size_regs[REG_TICK_NUM];
      nums[3] = size_regs[REG_LOT_NUM];
      nums[4] = size_regs[REG_ATOM_DEN];
      dens[0] = size_regs[REG_TICK_DEN];
      dens[1] = size_regs[REG_LOT_DEN];
      dens[2] = size_regs[REG_ATOM_NUM];
      // cancel each denominator against all numerators, in order
      for (int j = 0; j < 3; j++)
         for (int i = 0; i < 5; i++) begin
            g = euclid(nums[i], dens[j]);
            if (g != 0) begin
               nums[i] = nums[i] / g;
               dens[j] = dens[j] / g;
            end
         end
      for (int j = 0; j < 3; j++)
         if (dens[j] != 1) return make_word(ST_INEXACT, 0, t.side);
      for (int i = 0; i < 5; i++) begin
         if (mag != 0 && nums[i] > UMAX / mag) return make_word(ST_UOVF, 0, t.side);
         mag = mag * nums[i];
      end
      if (mag > SMAX) return make_word(ST_SOVF, 0, t.side);
      return make_word(ST_OK, mag, t.side);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
      errors++;
   endtask

   initial errors = 0;
   assign pending = notional_queue.size();

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         foreach (size_regs[k]) size_regs[k] = 64'd1;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[5:3] < CSR_COUNT)
            size_regs[csr_paddr[5:3]] = csr_pwdata;
         if (rsp_valid) begin
            if (notional_queue.size() == 0) begin
               report_mismatch("unexpected word", rsp_data[63:0], 0);
            end else begin
               want = notional_queue.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.notional != want.notional)
                  report_mismatch("notional", rsp_data.notional, want.notional);
               if (rsp_data.cash_effect != want.cash_effect)
                  report_mismatch("cash_effect", rsp_data.cash_effect, want.cash_effect);
            end
         end
         if (req_start && !req_busy) notional_queue.push_back(trade_notional(req_data));
      end
   end

endmodule

// File: bench/exact_rational_notional_tb.sv
// ----------------------------------------------------------------------------
// exact_rational_notional_tb: stimulus and verdict for exact_rational_notional
// Runs directed edge trades, then random trades across several size
// settings, written through the CSR port while the block is idle.
// ----------------------------------------------------------------------------
module exact_rational_notional_tb;
   import ern_pkg::*;

   localparam int STALL_LIMIT = 400000;

   logic                      clock = 0;
   logic                      reset = 1;
   logic                      req_start = 0;
   logic                      req_busy;
   req_type                   req_data = '0;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      csr_psel = 0;
   logic                      csr_penable = 0;
   logic                      csr_pwrite = 0;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr = '0;
   logic [63:0]               csr_pwdata = '0;
   logic [63:0]               csr_prdata;
   logic                      csr_pready;
   int                        errors;
   int                        pending;
   int                        stall_count = 0;
   logic [63:0]               sizes [CSR_COUNT] = '{default: 64'd1};
   bit                        steady = 0;

   always #5 clock = ~clock;

   exact_rational_notional u_top (.*);

   ern_notional_checker u_check (.*);

   // end the run if nothing moves for too long
   always @(posedge clock) begin
      if ((req_start && !req_busy) || rsp_valid) stall_count <= 0;
      else stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   function automatic logic [63:0] rand_word();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 19))
         0:       return v;
         1, 2, 3: return v & 64'hFFFF_FFFF;
         default: return v & 64'hFFF;
      endcase
   endfunction

   task automatic send_trade(logic side, logic [63:0] price, logic [63:0] qty);
      int gap;
      gap = (!steady && $urandom_range(0, 99) < 35) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_start <= 0;
         repeat (gap) @(posedge clock);
      end
      req_start <= 1;
      req_data  <= '{side: side, price: price, quantity: qty};
      do @(posedge clock); while (req_busy);
   endtask

   task automatic drain();
      req_start <= 0;
      @(posedge clock);
      while (pending != 0 || req_busy) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_size(reg_index_type idx, logic [63:0] value);
      csr_psel    <= 1;
      csr_penable <= 0;
      csr_pwrite  <= 1;
      csr_paddr   <= CSR_ADDR_WIDTH'(idx) << 3;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel    <= 0;
      csr_penable <= 0;
      sizes[idx] = value;
   endtask

   task automatic set_sizes(logic [63:0] tn, logic [63:0] td, logic [63:0] ln,
                            logic [63:0] ld, logic [63:0] an, logic [63:0] ad);
      drain();
      write_size(REG_TICK_NUM, tn);
      write_size(REG_TICK_DEN, td);
      write_size(REG_LOT_NUM, ln);
      write_size(REG_LOT_DEN, ld);
      write_size(REG_ATOM_NUM, an);
      write_size(REG_ATOM_DEN, ad);
   endtask

   task automatic random_trades(int count);
      logic [63:0] p;
      logic [63:0] q;
      for (int n = 0; n < count; n++) begin
         p = rand_word();
         q = rand_word();
         // mostly nonnegative, scaled so the denominators tend to cancel
         case ($urandom_range(0, 9))
            0:       p[63] = 1;
            1, 2:    p[63] = $urandom_range(0, 1);
            default: begin
               p[63] = 0;
               if (sizes[REG_TICK_DEN] < 4096 && sizes[REG_ATOM_NUM] < 4096)
                  p = (p & 64'hFFF) * sizes[REG_TICK_DEN] * sizes[REG_ATOM_NUM];
               if (sizes[REG_LOT_DEN] < 4096) q = (q & 64'hFFF) * sizes[REG_LOT_DEN];
            end
         endcase
         send_trade($urandom_range(0, 1), p, q);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // edges at unit sizes
      send_trade(0, 0, 64'd12345);
      send_trade(1, 64'd777, 0);
      send_trade(0, 64'h8000_0000_0000_0000, 1);
      send_trade(1, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_trade(1, 64'h7FFF_FFFF_FFFF_FFFF, 1);
      send_trade(0, 64'h7FFF_FFFF_FFFF_FFFF, 1);
      send_trade(1, 1, 64'hFFFF_FFFF_FFFF_FFFF);
      send_trade(0, 2, 64'h8000_0000_0000_0000);
      send_trade(1, 64'h4000_0000_0000_0000, 2);
      send_trade(0, 64'd3, 64'h5555_5555_5555_5555);
      // inexact and cancelling
      set_sizes(1, 100, 1, 10, 1, 1);
      send_trade(1, 64'd150, 64'd7);
      send_trade(0, 64'd1000, 64'd10);
      send_trade(1, 64'd0, 64'd3);
      // zero registers, one at a time (tick_num, atom_num, atom_den), and all-ones sizes
      set_sizes(0, 1, 1, 1, 1, 1);
      send_trade(1, 5, 5);
      set_sizes(1, 1, 1, 1, 0, 64'hFFFF_FFFF_FFFF_FFFF);
      send_trade(0, 64'h8000_0000_0000_0001, 5);
      set_sizes(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      send_trade(1, 64'd9, 64'd4);
      send_trade(0, 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      set_sizes(1, 1, 1, 1, 1, 0);
      send_trade(1, 5, 5);

      // random settings; one phase runs without idle gaps
      for (int ph = 0; ph < 6; ph++) begin
         steady = (ph == 3);
         if (ph == 0) set_sizes(1, 1, 1, 1, 1, 1);
         else if (ph == 5) set_sizes($urandom_range(0, 3), $urandom_range(1, 3), 1,
                                     $urandom_range(0, 2), 1, $urandom_range(1, 9));
         else set_sizes($urandom_range(1, 50), $urandom_range(1, 50), $urandom_range(1, 50),
                        $urandom_range(1, 50), $urandom_range(1, 50), $urandom_range(1, 50));
         random_trades(45);
      end
      steady = 0;

      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule

// File: files.f
rtl/core/ern_pkg.sv
rtl/core/ern_div.sv
rtl/core/ern_datapath.sv
rtl/core/ern_ctrl.sv
rtl/core/exact_rational_notional.sv
bench/ern_notional_checker.sv
bench/exact_rational_notional_tb.sv
